[rtl/sksl_pkg.sv]
// Shared constants, codes and types of the sorted key set lookup unit.
package sksl_pkg;

   // Key geometry: a key is KEY_WORDS words, word 0 most significant.
   localparam int KEY_WORDS   = 4;
   localparam int WORD_W      = 64;
   localparam int KEY_BITS    = KEY_WORDS * WORD_W;
   localparam int WORD_CNT_W  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

   // Table geometry.
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int TOTAL_W     = 11;

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream widths.
   localparam int FUNC_W      = 2;
   localparam int RSP_DATA_W  = 16;

   // Operation codes, used on the request tuser and the response tuser.
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

   // One classified command as it travels from front to back.
   typedef struct packed {
      logic [FUNC_W-1:0]   kind;
      logic [KEY_BITS-1:0] key;
   } cmd_type;

endpackage

[rtl/sksl_ram.sv]
// Generic simple dual-port RAM with a registered read port.
module sksl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sksl_front.sv]
// Front part: accepts request items, assembles keys and classifies commands.
module sksl_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sksl_pkg::WORD_W-1:0]  req_tdata,
   input  logic [sksl_pkg::FUNC_W-1:0]  req_tuser,
   output logic                         push_valid,
   input  logic                         push_ready,
   output sksl_pkg::cmd_type            push_cmd
);
   import sksl_pkg::*;

   logic [WORD_CNT_W-1:0] word_cnt_ff, word_cnt_in;
   logic [WORD_W-1:0]     buf_ff [KEY_WORDS];
   logic                  req_fire;
   logic                  is_word;
   logic                  last_word;
   logic [KEY_BITS-1:0]   key;

   // An item is taken whenever the queue has room for a command.
   assign req_tready = push_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_word    = (req_tuser == FUNC_LOAD) || (req_tuser == FUNC_QUERY);
   assign last_word  = (word_cnt_ff == WORD_CNT_W'(KEY_WORDS - 1));

   // The completed key: buffered words first, the arriving word last.
   always_comb begin
      key = '0;
      for (int i = 0; i < KEY_WORDS; i++) begin
         key[(KEY_WORDS - 1 - i) * WORD_W +: WORD_W] =
            (word_cnt_ff == WORD_CNT_W'(i)) ? req_tdata : buf_ff[i];
      end
   end

   // A clear, or the word that completes a key, becomes a command.
   assign push_valid    = req_fire && ((req_tuser == FUNC_CLEAR) || (is_word && last_word));
   assign push_cmd.kind = req_tuser;
   assign push_cmd.key  = key;

   // Word position within the key being assembled.
   always_comb begin
      word_cnt_in = word_cnt_ff;
      if (req_fire) begin
         if (req_tuser == FUNC_CLEAR) begin
            word_cnt_in = '0;
         end else if (is_word) begin
            word_cnt_in = last_word ? '0 : word_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_cnt_ff <= '0;
      end else begin
         word_cnt_ff <= word_cnt_in;
      end
   end

   // Assembly buffer for the leading words of a key.
   always_ff @(posedge clock) begin
      if (req_fire && is_word) begin
         buf_ff[word_cnt_ff] <= req_tdata;
      end
   end

endmodule

[rtl/sksl_queue.sv]
// Short command queue that decouples the front part from the back part.
module sksl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  sksl_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output sksl_pkg::cmd_type pop_cmd
);
   import sksl_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/sksl_back.sv]
// Back part: executes clear, load and query commands and drives the response.
module sksl_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  sksl_pkg::cmd_type                  pop_cmd,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sksl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [sksl_pkg::FUNC_W-1:0]        rsp_tuser
);
   import sksl_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PROBE = 2'd1;
   localparam logic [1:0] S_CMP   = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      entry_cnt_ff, entry_cnt_in;
   logic                  ordered_ff, ordered_in;
   logic [CNT_W-1:0]      lo_ff, lo_in;
   logic [CNT_W-1:0]      hi_ff, hi_in;
   logic [CNT_W-1:0]      mid_ff, mid_in;
   logic [CNT_W-1:0]      mid;
   logic [KEY_BITS-1:0]   qkey_ff, qkey_in;
   logic [KEY_BITS-1:0]   last_key_ff, last_key_in;
   logic                  res_found_ff, res_found_in;
   logic                  res_rej_ff, res_rej_in;
   logic [FUNC_W-1:0]     res_kind_ff, res_kind_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [FUNC_W-1:0]     rsp_user_ff, rsp_user_in;
   logic                  wr_en;
   logic                  rd_en;
   logic [KEY_BITS-1:0]   rd_data;

   // Key table, one full key per row.
   sksl_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (entry_cnt_ff[ADDR_W-1:0]),
      .wr_data (pop_cmd.key),
      .rd_en   (rd_en),
      .rd_addr (mid[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign pop_ready = (state_ff == S_IDLE);
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);

   // Command sequencer with the binary search loop.
   always_comb begin
      state_in     = state_ff;
      entry_cnt_in = entry_cnt_ff;
      ordered_in   = ordered_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      qkey_in      = qkey_ff;
      last_key_in  = last_key_ff;
      res_found_in = res_found_ff;
      res_rej_in   = res_rej_ff;
      res_kind_in  = res_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               res_found_in = 1'b0;
               res_rej_in   = 1'b0;
               res_kind_in  = pop_cmd.kind;
               state_in     = S_EMIT;
               if (pop_cmd.kind == FUNC_CLEAR) begin
                  entry_cnt_in = '0;
                  ordered_in   = 1'b1;
               end else if (pop_cmd.kind == FUNC_LOAD) begin
                  if (entry_cnt_ff >= CNT_W'(TABLE_DEPTH)) begin
                     res_rej_in = 1'b1;
                  end else begin
                     // A key must be strictly above the one loaded before it.
                     if ((entry_cnt_ff != '0) && (last_key_ff >= pop_cmd.key)) begin
                        ordered_in = 1'b0;
                     end
                     wr_en        = 1'b1;
                     last_key_in  = pop_cmd.key;
                     entry_cnt_in = entry_cnt_ff + 1'b1;
                  end
               end else begin
                  qkey_in  = pop_cmd.key;
                  lo_in    = '0;
                  hi_in    = entry_cnt_ff;
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               mid_in   = mid;
               state_in = S_CMP;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_CMP: begin
            if (rd_data == qkey_ff) begin
               res_found_in = 1'b1;
               state_in     = S_EMIT;
            end else if (rd_data < qkey_ff) begin
               lo_in    = mid_ff + 1'b1;
               state_in = S_PROBE;
            end else begin
               hi_in    = mid_ff;
               state_in = S_PROBE;
            end
         end
         S_EMIT: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, res_rej_ff, TOTAL_W'(entry_cnt_ff),
                               ordered_ff, res_found_ff};
               rsp_user_in  = res_kind_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         entry_cnt_ff <= '0;
         ordered_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entry_cnt_ff <= entry_cnt_in;
         ordered_ff   <= ordered_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Search bounds, keys and result payload.
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      qkey_ff      <= qkey_in;
      last_key_ff  <= last_key_in;
      res_found_ff <= res_found_in;
      res_rej_ff   <= res_rej_in;
      res_kind_ff  <= res_kind_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/sorted_key_set_lookup_unit.sv]
// Top level of the sorted key set lookup unit.
//
// Requests arrive one 64-bit key word per item on req_; tuser carries the
// operation (clear, load word, query word, or an unused code that is ignored).
// A clear item, or the word that completes a key, produces one response item
// on rsp_ with the found, ordered, entry total and rejected flags and the
// completed operation in tuser. Other items produce no response.
// The front part takes one word per cycle while its two-entry command queue
// has room; the back part executes commands one at a time.
// A query runs a binary search of at most ceil(log2(n + 1)) probes of the table
// for n loaded keys; each probe is one table read through the table's single
// registered read port plus one full key compare.
// Reset empties the table, sets the ordered flag and drops any partial key;
// the table memory itself needs no clearing pass.
// When the receiver stalls, the response holds in the output register, the
// back part finishes its current command and waits, and once the queue fills
// req_tready falls.
module sorted_key_set_lookup_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sksl_pkg::WORD_W-1:0]       req_tdata,  // [63:0] key_word
   input  logic [sksl_pkg::FUNC_W-1:0]       req_tuser,  // [1:0] func
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] found, [1] ordered, [12:2] entry_total, [13] rejected, [15:14] zero
   output logic [sksl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [sksl_pkg::FUNC_W-1:0]       rsp_tuser   // [1:0] kind
);
   import sksl_pkg::*;

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   sksl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   sksl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   sksl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Only a load can be rejected.
   a_reject_is_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[13]) |-> (rsp_tuser == FUNC_LOAD))
      else $error("rejected flag on a response that is not a load");

   // Only a query can report a hit.
   a_found_is_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tuser == FUNC_QUERY))
      else $error("found flag on a response that is not a query");

   // A clear leaves an empty, ordered table.
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == FUNC_CLEAR)) |->
         ((rsp_tdata[12:2] == '0) && rsp_tdata[1]))
      else $error("clear response does not show an empty ordered table");

   // Commands from the front are never offered to a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> push_ready)
      else $error("request accepted while the command queue is full");

endmodule

[tb/sksl_checker.sv]
// Checker that predicts and compares the responses of the sorted key set lookup unit.
`timescale 1ns / 1ps

module sksl_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [sksl_pkg::WORD_W-1:0]      req_tdata,   // [63:0] key_word
   input  logic [sksl_pkg::FUNC_W-1:0]      req_tuser,   // [1:0] func
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] found, [1] ordered, [12:2] entry_total, [13] rejected, [15:14] zero
   input  logic [sksl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [sksl_pkg::FUNC_W-1:0]      rsp_tuser,   // [1:0] kind
   output int                               mismatch_count,
   output int                               responses_due
);
   import sksl_pkg::*;

   // Fields of one response item as the table would report it.
   typedef struct {
      bit                  found;
      bit                  ordered;
      bit [TOTAL_W-1:0]    total;
      bit                  rejected;
      logic [FUNC_W-1:0]   kind;
   } lookup_rsp_type;

   // Shadow copy of the table, the sticky ordered flag and the key being assembled.
   logic [KEY_BITS-1:0] key_table [TABLE_DEPTH];
   int unsigned         key_count = 0;
   bit                  asc_flag  = 1'b1;
   logic [KEY_BITS-1:0] partial_key;
   int unsigned         words_in  = 0;
   lookup_rsp_type      due_responses [$];
   int                  errors    = 0;

   // Binary search over the held entries, exactly as the hardware probes them,
   // so an unordered table may miss a key that is present.
   function automatic bit table_holds(input logic [KEY_BITS-1:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = key_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (key_table[mid] == key)
            return 1'b1;
         if (key_table[mid] < key)
            lo = mid + 1;
         else
            hi = mid;
      end
      return 1'b0;
   endfunction

   task automatic expect_rsp(input bit found, input bit rejected, input logic [FUNC_W-1:0] kind);
      lookup_rsp_type rsp;
      rsp.found    = found;
      rsp.ordered  = asc_flag;
      rsp.total    = TOTAL_W'(key_count);
      rsp.rejected = rejected;
      rsp.kind     = kind;
      due_responses.push_back(rsp);
   endtask

   // Update the shadow state for one accepted request item.
   task automatic apply_request(input logic [FUNC_W-1:0] func, input logic [WORD_W-1:0] word);
      if (func == FUNC_CLEAR) begin
         key_count = 0;
         asc_flag  = 1'b1;
         words_in  = 0;
         expect_rsp(1'b0, 1'b0, FUNC_CLEAR);
      end else if (func == FUNC_LOAD || func == FUNC_QUERY) begin
         // Load and query words share one assembly buffer; the last word decides.
         partial_key[KEY_BITS - 1 - words_in * WORD_W -: WORD_W] = word;
         words_in++;
         if (words_in == KEY_WORDS) begin
            words_in = 0;
            if (func == FUNC_QUERY) begin
               expect_rsp(table_holds(partial_key), 1'b0, FUNC_QUERY);
            end else if (key_count >= TABLE_DEPTH) begin
               expect_rsp(1'b0, 1'b1, FUNC_LOAD);
            end else begin
               if (key_count > 0 && key_table[key_count - 1] >= partial_key)
                  asc_flag = 1'b0;
               key_table[key_count] = partial_key;
               key_count++;
               expect_rsp(1'b0, 1'b0, FUNC_LOAD);
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Compare one accepted response item with the oldest prediction.
   task automatic check_response(input logic [RSP_DATA_W-1:0] data,
                                 input logic [FUNC_W-1:0] kind);
      lookup_rsp_type want;
      if (due_responses.size() == 0) begin
         $display("%0t: unexpected response: expected none, actual tdata %h tuser %0d",
                  $time, data, kind);
         errors++;
      end else begin
         want = due_responses.pop_front();
         check_field("found", 16'(want.found), 16'(data[0]));
         check_field("ordered", 16'(want.ordered), 16'(data[1]));
         check_field("entry_total", 16'(want.total), 16'(data[2 +: TOTAL_W]));
         check_field("rejected", 16'(want.rejected), 16'(data[2 + TOTAL_W]));
         check_field("kind", 16'(want.kind), 16'(kind));
      end
   endtask

   // Watch both channels at every edge.
   always @(posedge clock) begin
      if (reset) begin
         due_responses.delete();
         key_count = 0;
         asc_flag  = 1'b1;
         words_in  = 0;
      end else begin
         if (req_tvalid && req_tready)
            apply_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_response(rsp_tdata, rsp_tuser);
      end
      responses_due  <= due_responses.size();
      mismatch_count <= errors;
   end

endmodule

[tb/tb.sv]
// Top of the testbench: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module tb;
   import sksl_pkg::*;

   localparam int ITEM_TARGET    = 900;
   localparam int TAIL_ITEMS     = 100;
   localparam int TAIL_CYCLES    = 100;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int FILL_KEYS      = 40;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [WORD_W-1:0]     req_tdata  = '0;   // [63:0] key_word
   logic [FUNC_W-1:0]     req_tuser  = FUNC_NONE;   // [1:0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] found, [1] ordered, [12:2] entry_total, [13] rejected, [15:14] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [FUNC_W-1:0]     rsp_tuser;   // [1:0] kind
   int                    mismatch_count;
   int                    responses_due;

   // Stimulus bookkeeping: keys loaded since the last clear, used to aim queries.
   logic [KEY_BITS-1:0]   held_keys [$];
   int                    items_sent   = 0;
   bit                    steady_tail  = 1'b0;
   int                    rsp_hold     = 0;
   int                    stuck_cycles = 0;

   sorted_key_set_lookup_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   sksl_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .responses_due  (responses_due)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver stalls in random bursts, none in the tail.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!steady_tail && $urandom_range(0, 9) == 0) begin
         rsp_hold   <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_BITS-1:0] rand_key();
      logic [KEY_BITS-1:0] key;
      for (int w = 0; w < KEY_WORDS; w++)
         key[w * WORD_W +: WORD_W] = rand_word();
      return key;
   endfunction

   // Offer one item, with an occasional idle gap first, and wait for acceptance.
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [WORD_W-1:0] word);
      if (!steady_tail && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (func != FUNC_NONE)
         items_sent++;
   endtask

   // Send a key most significant word first; the last word may use another operation.
   task automatic send_key(input logic [FUNC_W-1:0] body_func, input logic [FUNC_W-1:0] last_func,
                           input logic [KEY_BITS-1:0] key);
      for (int w = 0; w < KEY_WORDS; w++)
         send_item((w == KEY_WORDS - 1) ? last_func : body_func,
                   key[KEY_BITS - 1 - w * WORD_W -: WORD_W]);
   endtask

   task automatic load_key(input logic [KEY_BITS-1:0] key);
      send_key(FUNC_LOAD, FUNC_LOAD, key);
      if (held_keys.size() < TABLE_DEPTH)
         held_keys.push_back(key);
   endtask

   task automatic clear_table();
      send_item(FUNC_CLEAR, rand_word());
      held_keys.delete();
   endtask

   // Hold the request side until every predicted response has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (responses_due != 0);
   endtask

   initial begin : stimulus
      logic [KEY_BITS-1:0] key;
      logic [KEY_BITS-1:0] base;
      int                  episode;
      int                  pick;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, extreme keys, the ignored code mid-key,
      // mixed load and query words, duplicates and a clear in mid-key.
      send_key(FUNC_QUERY, FUNC_QUERY, '1);
      send_item(FUNC_LOAD, '0);
      send_item(FUNC_NONE, '1);
      repeat (KEY_WORDS - 1) send_item(FUNC_LOAD, '0);
      send_key(FUNC_LOAD, FUNC_LOAD, '1);
      send_key(FUNC_LOAD, FUNC_QUERY, '1);
      send_key(FUNC_QUERY, FUNC_LOAD, '1);
      send_item(FUNC_LOAD, rand_word());
      send_item(FUNC_QUERY, rand_word());
      send_item(FUNC_CLEAR, '1);

      // Fill part of the table in ascending order, then query it.
      clear_table();
      for (int i = 0; i < FILL_KEYS; i++) begin
         key = rand_key();
         key[KEY_BITS - 1 -: 16] = 16'(i);
         load_key(key);
      end
      drain_responses();
      repeat (10) begin
         if ($urandom_range(0, 1) != 0)
            key = held_keys[$urandom_range(0, held_keys.size() - 1)];
         else
            key = rand_key();
         send_key(FUNC_QUERY, FUNC_QUERY, key);
      end
      clear_table();

      // Random part: mostly well-formed load and query runs, some noise.
      while (items_sent < ITEM_TARGET) begin
         steady_tail = (items_sent >= ITEM_TARGET - TAIL_ITEMS);
         episode = $urandom_range(0, 9);
         if (episode <= 6) begin
            if ($urandom_range(0, 4) != 0)
               clear_table();
            base = (held_keys.size() != 0) ? held_keys[$] : (rand_key() >> $urandom_range(1, 32));
            repeat ($urandom_range(0, 12)) begin
               pick = $urandom_range(0, 9);
               if (pick < 7)
                  key = base + (rand_key() >> $urandom_range(8, KEY_BITS - 1)) + 1'b1;
               else if (pick == 7)
                  key = base;
               else
                  key = rand_key();
               load_key(key);
               base = key;
            end
            repeat ($urandom_range(1, 8)) begin
               pick = $urandom_range(0, 9);
               if (pick < 5 && held_keys.size() != 0) begin
                  key = held_keys[$urandom_range(0, held_keys.size() - 1)];
               end else if (pick == 5 && held_keys.size() != 0) begin
                  // A near miss just above or below a held key.
                  key = held_keys[$urandom_range(0, held_keys.size() - 1)];
                  key = ($urandom_range(0, 1) != 0) ? key + 1'b1 : key - 1'b1;
               end else begin
                  key = rand_key();
               end
               send_key(FUNC_QUERY, FUNC_QUERY, key);
            end
         end else if (episode == 7) begin
            repeat ($urandom_range(1, 6))
               send_item(FUNC_W'($urandom_range(0, 3)), rand_word());
         end else if (episode == 8) begin
            // A broken key: a few words, then maybe a clear.
            repeat ($urandom_range(1, KEY_WORDS - 1))
               send_item(($urandom_range(0, 1) != 0) ? FUNC_LOAD : FUNC_QUERY, rand_word());
            if ($urandom_range(0, 1) != 0)
               clear_table();
         end else begin
            drain_responses();
         end
      end

      // Let the last responses come back, then give the verdict.
      steady_tail = 1'b1;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (responses_due != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && responses_due == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[files.f]
rtl/sksl_pkg.sv
rtl/sksl_ram.sv
rtl/sksl_front.sv
rtl/sksl_queue.sv
rtl/sksl_back.sv
rtl/sorted_key_set_lookup_unit.sv
tb/sksl_checker.sv
tb/tb.sv
